### sv/dht_pkg.sv
package dht_pkg;

	localparam int unsigned TimeW  = 32;
	localparam int unsigned PerW   = 16;
	localparam int unsigned RateW  = 25;
	localparam int unsigned NumW   = 20;
	localparam int unsigned GainW  = 16;
	localparam int unsigned CfgW   = 20;
	localparam int unsigned FracW  = 8;
	localparam int unsigned DvdW   = NumW + FracW;
	localparam int unsigned StepW  = 5;

	localparam logic [NumW-1:0]  RpmNumReset    = NumW'(80357);
	localparam logic [GainW-1:0] SpeedGainReset = GainW'(27918);

	// command field codes
	localparam logic CMD_EDGE = 1'b0;
	localparam logic CMD_TICK = 1'b1;

	// configuration register indexes
	localparam logic REG_RPM_NUM    = 1'b0;
	localparam logic REG_SPEED_GAIN = 1'b1;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

### sv/dht_if.sv
interface dht_evt_if;
	logic                      valid;
	logic                      ready;
	logic                      command;
	logic                      sensor_a_edge;
	logic                      sensor_b_edge;
	logic [dht_pkg::TimeW-1:0] timer_value;

	modport source (output valid, command, sensor_a_edge, sensor_b_edge, timer_value,
		input ready);
	modport sink (input valid, command, sensor_a_edge, sensor_b_edge, timer_value,
		output ready);
endinterface

interface dht_res_if;
	logic                      valid;
	logic                      ready;
	logic [dht_pkg::RateW-1:0] rpm;
	logic [dht_pkg::RateW-1:0] speed;
	logic                      update_display;
	logic                      divide_error;

	modport source (output valid, rpm, speed, update_display, divide_error,
		input ready);
	modport sink (input valid, rpm, speed, update_display, divide_error,
		output ready);
endinterface

### sv/dht_div.sv
module dht_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [dht_pkg::DvdW-1:0]  dividend,
	input  logic [dht_pkg::PerW-1:0]  divisor,
	output logic [dht_pkg::DvdW-1:0]  quotient,
	output dht_pkg::div_stat_t        stat
);
	import dht_pkg::*;

	localparam logic [StepW-1:0] LastStep = StepW'(DvdW - 1);

	logic [PerW-1:0]  rem_q;
	logic [DvdW-1:0]  quo_q;
	logic [PerW-1:0]  dsr_q;
	logic [StepW-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;

	logic [PerW:0]    shifted;
	logic [PerW+1:0]  diff;
	logic             fits;

	// one restoring step: shared subtract/compare
	assign shifted = {rem_q, quo_q[DvdW-1]};
	assign diff    = {1'b0, shifted} - {2'b00, dsr_q};
	assign fits    = ~diff[PerW+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q  <= '0;
			quo_q  <= '0;
			dsr_q  <= '0;
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				rem_q  <= '0;
				quo_q  <= dividend;
				dsr_q  <= divisor;
				cnt_q  <= LastStep;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				rem_q <= fits ? diff[PerW-1:0] : shifted[PerW-1:0];
				quo_q <= {quo_q[DvdW-2:0], fits};
				cnt_q <= cnt_q - StepW'(1);
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign quotient  = quo_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

### sv/dual_hall_tachometer.sv
// Channel | Dir | Fields                                            | Handshake
// evt     | in  | command, sensor_a_edge, sensor_b_edge, timer_value | valid/ready
// res     | out | rpm, speed, update_display, divide_error          | valid/ready
// cfg     | in  | cfg_index, cfg_data                               | cfg_we, no wait
//
// An edge item that names a sensor goes from accept to result in these steps:
// add the periods, run the restoring divider (one quotient bit per cycle),
// see the divider finish, do the gain multiply, and load the result
// register; input is ready again in the cycle after the load.
// A non-positive period sum skips the divider and goes straight to the load.
// Ticks and edges with no sensor also go straight to the result load.
// One item in flight at a time. Reset sets all state at once; no clearing pass.
// A full output register holds the sequencer in its last state; once loaded,
// a stalled result waits there while the next item is taken.
module dual_hall_tachometer (
	input  logic                     clk,
	input  logic                     arst_n,
	dht_evt_if.sink                  evt,
	dht_res_if.source                res,
	input  logic                     cfg_we,
	input  logic                     cfg_index,
	input  logic [dht_pkg::CfgW-1:0] cfg_data
);
	import dht_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SUM,
		ST_DIV,
		ST_MUL,
		ST_FINISH
	} state_t;

	state_t state_q;

	// configuration
	logic [NumW-1:0]  rpm_num_q;
	logic [GainW-1:0] gain_q;

	// tachometer state
	logic [TimeW-1:0] last_a_q;
	logic [TimeW-1:0] last_b_q;
	logic [PerW-1:0]  per_a_q;
	logic [PerW-1:0]  per_b_q;
	logic [RateW-1:0] rpm_q;
	logic [RateW-1:0] speed_q;
	logic             spin_q;

	// result of the item in flight
	logic             upd_q;
	logic             err_q;

	// output register
	logic             res_vld_q;
	logic [RateW-1:0] res_rpm_q;
	logic [RateW-1:0] res_speed_q;
	logic             res_upd_q;
	logic             res_err_q;

	logic             evt_fire;
	logic             res_free;
	logic [TimeW-1:0] diff_a;
	logic [TimeW-1:0] diff_b;
	logic [PerW:0]    per_sum;
	logic             sum_pos;
	logic             div_start;
	logic [DvdW-1:0]  quo;
	div_stat_t        div_stat;
	logic [RateW-1:0] rpm_sat;
	logic [RateW+GainW-1:0] prod;

	assign evt_fire = evt.valid && evt.ready;
	assign res_free = !res_vld_q || res.ready;

	// timer counts down: period is old stamp minus new, wrapping
	assign diff_a = last_a_q - evt.timer_value;
	assign diff_b = last_b_q - evt.timer_value;

	// periods are signed 16 bit; their sum is 17 bit signed
	assign per_sum   = {per_a_q[PerW-1], per_a_q} + {per_b_q[PerW-1], per_b_q};
	assign sum_pos   = !per_sum[PerW] && (per_sum != '0);
	assign div_start = (state_q == ST_SUM) && sum_pos;

	dht_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend ({rpm_num_q, {FracW{1'b0}}}),
		.divisor  (per_sum[PerW-1:0]),
		.quotient (quo),
		.stat     (div_stat)
	);

	// saturate the Q.8 quotient, then scale by the Q0.16 gain
	assign rpm_sat = (quo[DvdW-1:RateW] != '0) ? {RateW{1'b1}} : quo[RateW-1:0];
	assign prod    = rpm_sat * gain_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rpm_num_q <= RpmNumReset;
			gain_q    <= SpeedGainReset;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_RPM_NUM:    rpm_num_q <= cfg_data[NumW-1:0];
				REG_SPEED_GAIN: gain_q    <= cfg_data[GainW-1:0];
				default:        ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			last_a_q    <= '1;
			last_b_q    <= '1;
			per_a_q     <= '0;
			per_b_q     <= '0;
			rpm_q       <= '0;
			speed_q     <= '0;
			spin_q      <= 1'b0;
			upd_q       <= 1'b0;
			err_q       <= 1'b0;
			res_vld_q   <= 1'b0;
			res_rpm_q   <= '0;
			res_speed_q <= '0;
			res_upd_q   <= 1'b0;
			res_err_q   <= 1'b0;
		end else begin
			// in ST_FINISH the output register is refilled or still stalled
			if (res_vld_q && res.ready && (state_q != ST_FINISH))
				res_vld_q <= 1'b0;

			unique case (state_q)
				ST_IDLE: begin
					if (evt_fire) begin
						upd_q <= 1'b0;
						err_q <= 1'b0;
						state_q <= ST_FINISH;
						if (evt.command == CMD_TICK) begin
							// spinning wins; else a stopped rotor with nonzero speed zeroes the rates
							if (spin_q) begin
								spin_q <= 1'b0;
								upd_q  <= 1'b1;
							end else if (speed_q != '0) begin
								rpm_q   <= '0;
								speed_q <= '0;
								upd_q   <= 1'b1;
							end
						end else begin
							if (evt.sensor_a_edge) begin
								per_a_q  <= diff_a[PerW-1:0];
								last_a_q <= evt.timer_value;
							end
							if (evt.sensor_b_edge) begin
								per_b_q  <= diff_b[PerW-1:0];
								last_b_q <= evt.timer_value;
							end
							// both sensors: a single recompute uses both new periods
							if (evt.sensor_a_edge || evt.sensor_b_edge) begin
								spin_q  <= 1'b1;
								state_q <= ST_SUM;
							end
						end
					end
				end
				ST_SUM: begin
					if (sum_pos) begin
						state_q <= ST_DIV;
					end else begin
						rpm_q   <= '0;
						speed_q <= '0;
						err_q   <= 1'b1;
						state_q <= ST_FINISH;
					end
				end
				ST_DIV: begin
					if (div_stat.done)
						state_q <= ST_MUL;
				end
				ST_MUL: begin
					rpm_q   <= rpm_sat;
					speed_q <= prod[RateW+GainW-1:GainW];
					state_q <= ST_FINISH;
				end
				ST_FINISH: begin
					// hold until the output register is free
					if (res_free) begin
						res_vld_q   <= 1'b1;
						res_rpm_q   <= rpm_q;
						res_speed_q <= speed_q;
						res_upd_q   <= upd_q;
						res_err_q   <= err_q;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign evt.ready          = (state_q == ST_IDLE);
	assign res.valid          = res_vld_q;
	assign res.rpm            = res_rpm_q;
	assign res.speed          = res_speed_q;
	assign res.update_display = res_upd_q;
	assign res.divide_error   = res_err_q;

	// input is not ready in the cycle after an accept
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		evt_fire |=> !evt.ready)
		else $error("input ready right after an accept");

	// the divider only runs while the sequencer waits on it
	a_div_in_div_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_stat.busy |-> (state_q == ST_DIV))
		else $error("divider busy outside the divide state");

	// gain is below one, so speed never exceeds rpm
	a_speed_le_rpm: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> (res.speed <= res.rpm))
		else $error("speed above rpm");

	// a divide error forces both rates to zero and is never a refresh
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && res.divide_error) |->
			(res.rpm == '0) && (res.speed == '0) && !res.update_display)
		else $error("divide error with nonzero rates or refresh");

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 100ps

module testbench;
	import dht_pkg::*;

	// one result item per input item, as the block should produce it
	typedef struct packed {
		logic [RateW-1:0] rpm;
		logic [RateW-1:0] speed;
		logic             update_display;
		logic             divide_error;
	} tach_result_t;

	localparam logic [RateW-1:0] RateMax = {RateW{1'b1}};
	localparam int unsigned SettleCycles = 40;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic cfg_index;
	logic [CfgW-1:0] cfg_data;

	dht_evt_if evt_ch ();
	dht_res_if res_ch ();

	dual_hall_tachometer u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.evt      (evt_ch),
		.res      (res_ch),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	// 20 ns period
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Rate model: own copy of the configuration and rotor state.
	// ------------------------------------------------------------------
	logic [NumW-1:0]         numerator_q;
	logic [GainW-1:0]        gain_q;
	logic [TimeW-1:0]        last_stamp_a;
	logic [TimeW-1:0]        last_stamp_b;
	logic signed [PerW-1:0]  period_a_q;
	logic signed [PerW-1:0]  period_b_q;
	logic [RateW-1:0]        rpm_q;
	logic [RateW-1:0]        speed_q;
	logic                    spinning_q;

	tach_result_t pending_results[$]; // results still owed by the block, oldest first
	int unsigned  mismatch_count = 0;

	// idling switches for each side
	bit src_idle_on = 1'b1;
	bit snk_idle_on = 1'b1;

	// running down-counter used to build well-formed edge sequences
	logic [TimeW-1:0] seq_time;

	task automatic report_mismatch(input string msg);
		mismatch_count++;
		$display("[%0t] mismatch: %s", $realtime, msg);
	endtask

	// Recompute rpm/speed from the two stored periods; returns 1 on a sum <= 0.
	function automatic logic rates_from_periods();
		logic signed [PerW:0] period_sum;
		logic [DvdW-1:0]      dividend;
		longint unsigned      quotient;
		period_sum = period_a_q + period_b_q;
		if (period_sum <= 0) begin
			rpm_q   = '0;
			speed_q = '0;
			return 1'b1;
		end
		dividend = {numerator_q, {FracW{1'b0}}};
		quotient = longint'(dividend) / longint'(period_sum[PerW-1:0]);
		if (quotient > longint'(RateMax))
			quotient = longint'(RateMax);
		rpm_q   = quotient[RateW-1:0];
		speed_q = RateW'((quotient * longint'(gain_q)) >> 16);
		return 1'b0;
	endfunction

	// Advance the model by one accepted input item and queue its result.
	function automatic void predict_tach(input logic cmd, input logic sa, input logic sb,
		input logic [TimeW-1:0] stamp);
		tach_result_t r;
		logic [TimeW-1:0] diff;
		logic err;
		logic upd;
		err = 1'b0;
		upd = 1'b0;
		if (cmd == CMD_EDGE) begin
			// sensor a first, then b; the flag follows the last recompute
			if (sa) begin
				diff         = last_stamp_a - stamp;
				period_a_q   = diff[PerW-1:0];
				last_stamp_a = stamp;
				spinning_q   = 1'b1;
				err          = rates_from_periods();
			end
			if (sb) begin
				diff         = last_stamp_b - stamp;
				period_b_q   = diff[PerW-1:0];
				last_stamp_b = stamp;
				spinning_q   = 1'b1;
				err          = rates_from_periods();
			end
		end else begin
			if (spinning_q) begin
				upd        = 1'b1;
				spinning_q = 1'b0;
			end else if (speed_q != '0) begin
				// rotor stopped: drop the gauges to zero
				rpm_q   = '0;
				speed_q = '0;
				upd     = 1'b1;
			end
		end
		r.rpm            = rpm_q;
		r.speed          = speed_q;
		r.update_display = upd;
		r.divide_error   = err;
		pending_results.push_back(r);
	endfunction

	// ------------------------------------------------------------------
	// Driving side
	// ------------------------------------------------------------------
	// Called right after a rising edge. Valid stays high after the accept so
	// back-to-back items need no gap; it drops only in an idle cycle or in a drain.
	task automatic send_item(input logic cmd, input logic sa, input logic sb,
		input logic [TimeW-1:0] stamp);
		while (src_idle_on && $urandom_range(99) < 22) begin
			evt_ch.valid <= 1'b0;
			@(posedge clk);
		end
		evt_ch.valid         <= 1'b1;
		evt_ch.command       <= cmd;
		evt_ch.sensor_a_edge <= sa;
		evt_ch.sensor_b_edge <= sb;
		evt_ch.timer_value   <= stamp;
		do
			@(posedge clk);
		while (!evt_ch.ready);
		predict_tach(cmd, sa, sb, stamp);
	endtask

	// Stop sending and wait until every owed result is back, then let the
	// block settle so a register write cannot land mid-computation.
	task automatic drain_block();
		evt_ch.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SettleCycles) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [CfgW-1:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_RPM_NUM)
			numerator_q = value[NumW-1:0];
		else
			gain_q = value[GainW-1:0];
		@(posedge clk);
	endtask

	// Mostly plausible rotation (timer counting down, sensors singly or
	// together), with ticks mixed in, plus noise and out-of-range gaps.
	task automatic send_random();
		int unsigned pick;
		int unsigned which;
		logic [TimeW-1:0] gap;
		pick = $urandom_range(99);
		if (pick < 15) begin
			// tick: sensor and timer fields are don't-care, so randomize them
			send_item(CMD_TICK, 1'($urandom_range(1)), 1'($urandom_range(1)), $urandom());
		end else if (pick < 25) begin
			// noise: arbitrary stamp, any sensor mix including none
			send_item(CMD_EDGE, 1'($urandom_range(1)), 1'($urandom_range(1)), $urandom());
		end else begin
			if (pick < 32)
				gap = $urandom_range(20000, 200000); // period may overflow the 16-bit cut
			else if (pick < 40)
				gap = $urandom_range(0, 40);
			else
				gap = $urandom_range(200, 16000);
			seq_time = seq_time - gap;
			which = $urandom_range(9);
			if (which < 4)
				send_item(CMD_EDGE, 1'b1, 1'b0, seq_time);
			else if (which < 8)
				send_item(CMD_EDGE, 1'b0, 1'b1, seq_time);
			else
				send_item(CMD_EDGE, 1'b1, 1'b1, seq_time);
		end
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------
	task automatic test_reset_behavior();
		// tick on a stopped rotor: nothing to refresh
		send_item(CMD_TICK, 1'b1, 1'b1, '1);
		// edge naming no sensor changes nothing
		send_item(CMD_EDGE, 1'b0, 1'b0, 32'h1234_5678);
		// same stamp as the reset timestamp: zero period, zero sum
		send_item(CMD_EDGE, 1'b1, 1'b0, 32'hFFFF_FFFF);
		send_item(CMD_EDGE, 1'b1, 1'b0, 32'hFFFF_FF00);
		send_item(CMD_EDGE, 1'b0, 1'b1, 32'hFFFF_FE00);
		// both sensors in one item
		send_item(CMD_EDGE, 1'b1, 1'b1, 32'hFFFF_FC00);
		// spinning tick, then stopped tick with speed, then stopped and zero
		send_item(CMD_TICK, 1'b0, 1'b0, 32'h0);
		send_item(CMD_TICK, 1'b0, 1'b1, 32'h5555_AAAA);
		send_item(CMD_TICK, 1'b1, 1'b0, 32'hAAAA_5555);
		// period over 0x7FFF goes negative after the cut
		send_item(CMD_EDGE, 1'b1, 1'b0, 32'hFFFF_6C00);
		send_item(CMD_EDGE, 1'b0, 1'b1, 32'hFFFE_EC01);
		// timer wraps through zero between consecutive edges of sensor a
		send_item(CMD_EDGE, 1'b1, 1'b0, 32'h0000_0100);
		send_item(CMD_EDGE, 1'b1, 1'b0, 32'hFFFF_FF00);
		send_item(CMD_TICK, 1'b0, 1'b0, 32'h0);
	endtask

	task automatic test_config_extremes();
		drain_block();
		write_reg(REG_RPM_NUM, CfgW'({NumW{1'b1}}));
		write_reg(REG_SPEED_GAIN, CfgW'({GainW{1'b1}}));
		// sum of one: quotient saturates, speed at its largest
		send_item(CMD_EDGE, 1'b0, 1'b1, last_stamp_b);
		send_item(CMD_EDGE, 1'b1, 1'b0, last_stamp_a - 32'd1);
		send_item(CMD_TICK, 1'b0, 1'b0, 32'h0);
		send_item(CMD_TICK, 1'b0, 1'b0, 32'h0);
		drain_block();
		write_reg(REG_RPM_NUM, '0);
		write_reg(REG_SPEED_GAIN, '0);
		// zero numerator: zero rate but no divide error
		send_item(CMD_EDGE, 1'b1, 1'b0, last_stamp_a - 32'd300);
		send_item(CMD_TICK, 1'b0, 1'b0, 32'h0);
		send_item(CMD_TICK, 1'b0, 1'b0, 32'h0);
		drain_block();
		write_reg(REG_RPM_NUM, CfgW'(1));
		write_reg(REG_SPEED_GAIN, CfgW'({GainW{1'b1}}));
		// nonzero rpm with gain zero would keep rpm through a stopped tick;
		// here largest periods give a quotient of zero
		send_item(CMD_EDGE, 1'b1, 1'b1, last_stamp_a - 32'h7FFF);
		send_item(CMD_EDGE, 1'b0, 1'b1, last_stamp_b - 32'h7FFF);
		send_item(CMD_TICK, 1'b0, 1'b0, 32'h0);
		drain_block();
		write_reg(REG_RPM_NUM, CfgW'(RpmNumReset));
		write_reg(REG_SPEED_GAIN, '0);
		// gain zero: speed stays zero, so a stopped tick leaves rpm alone
		send_item(CMD_EDGE, 1'b1, 1'b0, last_stamp_a - 32'd500);
		send_item(CMD_TICK, 1'b0, 1'b0, 32'h0);
		send_item(CMD_TICK, 1'b0, 1'b0, 32'h0);
	endtask

	task automatic test_back_to_back();
		drain_block();
		write_reg(REG_RPM_NUM, CfgW'(RpmNumReset));
		write_reg(REG_SPEED_GAIN, CfgW'(SpeedGainReset));
		// long stretch with neither side idling
		src_idle_on = 1'b0;
		snk_idle_on = 1'b0;
		repeat (150) send_random();
		src_idle_on = 1'b1;
		snk_idle_on = 1'b1;
	endtask

	task automatic test_config_sweep();
		int unsigned phase;
		logic [CfgW-1:0] num_val;
		logic [CfgW-1:0] gain_val;
		for (phase = 0; phase < 5; phase++) begin
			drain_block();
			num_val  = CfgW'($urandom_range(0, (1 << NumW) - 1));
			gain_val = CfgW'($urandom_range(0, (1 << GainW) - 1));
			if (phase == 1)
				num_val = CfgW'({NumW{1'b1}});
			if (phase == 3)
				gain_val = CfgW'({GainW{1'b1}});
			write_reg(REG_RPM_NUM, num_val);
			write_reg(REG_SPEED_GAIN, gain_val);
			repeat (70) send_random();
		end
	endtask

	// ------------------------------------------------------------------
	// Result side: random back-pressure and in-order compare
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (!arst_n)
			res_ch.ready <= 1'b0;
		else if (snk_idle_on)
			res_ch.ready <= ($urandom_range(99) >= 22);
		else
			res_ch.ready <= 1'b1;
	end

	always @(posedge clk) begin : result_check
		tach_result_t want;
		if (res_ch.valid && res_ch.ready) begin
			if (pending_results.size() == 0) begin
				report_mismatch($sformatf("result with nothing owed: rpm=%0d speed=%0d",
					res_ch.rpm, res_ch.speed));
			end else begin
				want = pending_results.pop_front();
				if (res_ch.rpm !== want.rpm)
					report_mismatch($sformatf("rpm %0d, want %0d", res_ch.rpm, want.rpm));
				if (res_ch.speed !== want.speed)
					report_mismatch($sformatf("speed %0d, want %0d",
						res_ch.speed, want.speed));
				if (res_ch.update_display !== want.update_display)
					report_mismatch($sformatf("update_display %b, want %b",
						res_ch.update_display, want.update_display));
				if (res_ch.divide_error !== want.divide_error)
					report_mismatch($sformatf("divide_error %b, want %b",
						res_ch.divide_error, want.divide_error));
			end
		end
	end

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin
		arst_n               <= 1'b0;
		cfg_we               <= 1'b0;
		cfg_index            <= REG_RPM_NUM;
		cfg_data             <= '0;
		evt_ch.valid         <= 1'b0;
		evt_ch.command       <= CMD_EDGE;
		evt_ch.sensor_a_edge <= 1'b0;
		evt_ch.sensor_b_edge <= 1'b0;
		evt_ch.timer_value   <= '0;

		// model state after reset
		numerator_q  = RpmNumReset;
		gain_q       = SpeedGainReset;
		last_stamp_a = '1;
		last_stamp_b = '1;
		period_a_q   = '0;
		period_b_q   = '0;
		rpm_q        = '0;
		speed_q      = '0;
		spinning_q   = 1'b0;
		seq_time     = $urandom();

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_behavior();
		test_config_extremes();
		test_back_to_back();
		test_config_sweep();

		evt_ch.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SettleCycles) @(posedge clk);
		if (mismatch_count == 0)
			$display("PASS dual_hall_tachometer");
		else
			$display("FAIL dual_hall_tachometer");
		$finish;
	end

	// hang guard: far beyond the slowest legal run
	initial begin
		#20000000;
		$display("FAIL dual_hall_tachometer");
		$finish;
	end

endmodule

### dual_hall_tachometer.f
sv/dht_pkg.sv
sv/dht_if.sv
sv/dht_div.sv
sv/dual_hall_tachometer.sv
tb/sv/testbench.sv
